// ===== rtl/fla_pkg.sv =====
// fla_pkg: shared types and constants of the free list slot allocator
// depends on nothing; imported by the channel interfaces and the core
`timescale 1ns / 1ps
`default_nettype none

package fla_pkg;

    localparam int unsigned SLOT_W            = 8;
    localparam int unsigned COUNT_W           = 9;
    localparam int unsigned MAX_SLOTS_DEFAULT = 256;
    localparam int unsigned SLOT_CAP          = 256;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;
    localparam logic [COUNT_W-1:0] COUNT_MIN   = 9'd2;

    localparam logic ACT_OBTAIN = 1'b0;
    localparam logic ACT_RETURN = 1'b1;

    typedef enum logic [1:0] {
        ST_GRANTED  = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_RETURNED = 2'd2,
        ST_REFUSED  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_HOLD
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/fla_ifs.sv =====
// fla_ifs: valid/ready channel interfaces for requests and responses
// depends on fla_pkg
`timescale 1ns / 1ps
`default_nettype none

interface fla_req_if
    import fla_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              action;
    logic [SLOT_W-1:0] slot;

    modport source (output valid, output action, output slot, input ready);
    modport sink   (input valid, input action, input slot, output ready);
endinterface

interface fla_rsp_if
    import fla_pkg::*;
;
    logic              valid;
    logic              ready;
    status_t           status;
    logic [SLOT_W-1:0] granted_slot;

    modport source (output valid, output status, output granted_slot, input ready);
    modport sink   (input valid, input status, input granted_slot, output ready);
endinterface

`default_nettype wire

// ===== rtl/free_list_slot_allocator_core.sv =====
// free_list_slot_allocator_core: lifo free list of pool slots kept in a link memory
// depends on fla_pkg and the channel interfaces in fla_ifs
`timescale 1ns / 1ps
`default_nettype none

// channel      dir   handshake      payload
// req          in    valid/ready    action, slot
// rsp          out   valid/ready    status, granted_slot
// cfg_wr_en    in    write enable   cfg_wr_data = slot_count (9 bits)
//
// a return or a refused/empty item is answered in the idle state; a grant goes
//   via the read state, as the popped slot's link comes from the synchronous memory
// one item in flight at a time; the next is taken once this one's result has
//   reached the output register; a result parked in the hold register (output
//   stalled) keeps the input stalled until it moves into the output register
// an output register parts the sides: a new item is taken while a result waits
// reset (or a count write) rebuilds the chain at once: per-entry valid bits mark
//   written links, an unwritten entry reads as its chain value, no clearing pass

module free_list_slot_allocator_core
    import fla_pkg::*;
#(
    parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    fla_req_if.sink                 req,
    fla_rsp_if.source               rsp,
    input  wire logic               cfg_wr_en,
    input  wire logic [COUNT_W-1:0] cfg_wr_data
);

    // link memory depth: slots never exceed the 8-bit slot space
    localparam int unsigned DEPTH = (MAX_SLOTS < SLOT_CAP) ? MAX_SLOTS : SLOT_CAP;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam logic [COUNT_W-1:0] CAP = COUNT_W'(DEPTH);

    // configuration and list state
    logic [COUNT_W-1:0] count_reg;
    logic [SLOT_W-1:0]  head_reg;
    logic [DEPTH-1:0]   lvalid_reg;
    state_t             state_reg, state_next;

    // link memory
    logic [SLOT_W-1:0]  link_mem [DEPTH];
    logic [SLOT_W-1:0]  rd_data_reg;

    // item being granted, and a result parked while the output is stalled
    logic [SLOT_W-1:0]  grant_reg;
    status_t            pend_status_reg;
    logic [SLOT_W-1:0]  pend_slot_reg;

    // output register
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg;
    logic [SLOT_W-1:0]  out_slot_reg;

    // control
    logic               ready_c;
    logic               acc_c;
    logic               out_free_c;
    logic               res_valid_c;
    status_t            res_status_c;
    logic [SLOT_W-1:0]  res_slot_c;
    logic               mem_re_c;
    logic               mem_we_c;
    logic               head_we_c;
    logic [SLOT_W-1:0]  head_wdata_c;

    // derived values
    logic [COUNT_W-1:0] eff_count_c;
    logic               empty_c;
    logic               ret_ok_c;
    logic [COUNT_W-1:0] grant_inc_c;
    logic [SLOT_W-1:0]  link_default_c;
    logic [SLOT_W-1:0]  link_value_c;

    // count saturated to [2, CAP]
    always_comb
    begin
        if (count_reg < COUNT_MIN)
            eff_count_c = COUNT_MIN;
        else if (count_reg > CAP)
            eff_count_c = CAP;
        else
            eff_count_c = count_reg;
    end

    assign empty_c  = (head_reg == '0) || ({1'b0, head_reg} >= eff_count_c);
    assign ret_ok_c = (req.slot != '0) && ({1'b0, req.slot} < eff_count_c);

    // link of an entry never written since the chain was formed
    assign grant_inc_c    = {1'b0, grant_reg} + COUNT_W'(1);
    assign link_default_c = (grant_inc_c < eff_count_c) ? grant_inc_c[SLOT_W-1:0] : '0;
    assign link_value_c   = lvalid_reg[grant_reg[AW-1:0]] ? rd_data_reg : link_default_c;

    assign ready_c    = (state_reg == S_IDLE);
    assign acc_c      = req.valid && ready_c;
    assign out_free_c = !out_valid_reg || rsp.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc_c && (req.action == ACT_OBTAIN) && !empty_c)
                    state_next = S_READ;
                else if (acc_c && !out_free_c)
                    state_next = S_HOLD;
            end
            S_READ:
            begin
                state_next = out_free_c ? S_IDLE : S_HOLD;
            end
            S_HOLD:
            begin
                if (out_free_c)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        res_valid_c  = 1'b0;
        res_status_c = ST_EMPTY;
        res_slot_c   = '0;
        mem_re_c     = 1'b0;
        mem_we_c     = 1'b0;
        head_we_c    = 1'b0;
        head_wdata_c = req.slot;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc_c)
                begin
                    if (req.action == ACT_OBTAIN)
                    begin
                        if (empty_c)
                        begin
                            res_valid_c  = 1'b1;
                            res_status_c = ST_EMPTY;
                        end
                        else
                        begin
                            // fetch the link of the slot being popped
                            mem_re_c = 1'b1;
                        end
                    end
                    else
                    begin
                        res_valid_c = 1'b1;
                        if (ret_ok_c)
                        begin
                            // push: returned slot links to the old head
                            res_status_c = ST_RETURNED;
                            mem_we_c     = 1'b1;
                            head_we_c    = 1'b1;
                            head_wdata_c = req.slot;
                        end
                        else
                        begin
                            res_status_c = ST_REFUSED;
                        end
                    end
                end
            end
            S_READ:
            begin
                res_valid_c  = 1'b1;
                res_status_c = ST_GRANTED;
                res_slot_c   = grant_reg;
                head_we_c    = 1'b1;
                head_wdata_c = link_value_c;
            end
            S_HOLD:
            begin
                res_valid_c  = 1'b1;
                res_status_c = pend_status_reg;
                res_slot_c   = pend_slot_reg;
            end
            default:
            begin
                res_valid_c = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (res_valid_c && out_free_c)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= COUNT_RESET;
            head_reg      <= SLOT_W'(1);
            lvalid_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                // new count: chain re-forms, head back at slot 1
                count_reg  <= cfg_wr_data;
                head_reg   <= SLOT_W'(1);
                lvalid_reg <= '0;
            end
            else
            begin
                if (head_we_c)
                    head_reg <= head_wdata_c;
                if (mem_we_c)
                    lvalid_reg[req.slot[AW-1:0]] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (mem_re_c)
            grant_reg <= head_reg;
        if (res_valid_c && !out_free_c)
        begin
            pend_status_reg <= res_status_c;
            pend_slot_reg   <= res_slot_c;
        end
        if (res_valid_c && out_free_c)
        begin
            out_status_reg <= res_status_c;
            out_slot_reg   <= res_slot_c;
        end
    end

    // link memory, one write and one read port, registered read data
    always_ff @(posedge clk)
    begin
        if (mem_we_c)
            link_mem[req.slot[AW-1:0]] <= head_reg;
        if (mem_re_c)
            rd_data_reg <= link_mem[head_reg[AW-1:0]];
    end

    assign req.ready        = ready_c;
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.granted_slot = out_slot_reg;

`ifndef SYNTHESIS
    // head never leaves the active slot range (zero means empty)
    a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, head_reg} < eff_count_c)
        else $error("free head outside the active slot range");

    // a grant never hands out the sentinel slot
    a_grant_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == ST_GRANTED)) |-> (rsp.granted_slot != '0))
        else $error("sentinel slot granted");

    // every non-grant result carries slot zero
    a_other_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != ST_GRANTED)) |-> (rsp.granted_slot == '0))
        else $error("non-grant result with a slot number");

    // the sequencer never stays in the read state; the result is formed there
    a_read_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> (state_reg != S_READ))
        else $error("sequencer stuck in read");

    // an obtain with a free slot always goes to the memory read
    a_obtain_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_c && (req.action == ACT_OBTAIN) && !empty_c) |=> (state_reg == S_READ))
        else $error("obtain did not read the link memory");
`endif

endmodule

`default_nettype wire

// ===== verif/free_list_slot_allocator_core_tb.sv =====
// free_list_slot_allocator_core_tb: self-checking bench for the slot allocator core
// drives obtain/return items through the request channel, predicts every response
// with its own free list copy; depends on fla_pkg, fla_ifs and the core
`timescale 1ns / 1ps

module free_list_slot_allocator_core_tb
    import fla_pkg::*;
;

    // generous bound: ~1550 items, each at worst a sender gap, a receiver stall
    // and the grant path through the read state, taken many times over
    localparam int unsigned CYCLE_LIMIT = 400000;

    // two copies of the free list: one follows accepted items, one plans stimulus
    localparam int POOL_LIVE = 0;
    localparam int POOL_PLAN = 1;

    typedef struct packed {
        logic              action;
        logic [SLOT_W-1:0] slot;
    } req_item_t;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] granted_slot;
    } rsp_item_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [COUNT_W-1:0] cfg_wr_data;

    fla_req_if req ();
    fla_rsp_if rsp ();

    free_list_slot_allocator_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // free list copies: count register, head of list, link memory
    logic [COUNT_W-1:0] count_reg [2];
    logic [SLOT_W-1:0]  head_slot [2];
    logic [SLOT_W-1:0]  link_mem  [2][SLOT_CAP];

    req_item_t         pending_reqs [$];   // items not yet accepted by the core
    rsp_item_t         awaited_rsps [$];   // predicted responses, oldest first
    logic [SLOT_W-1:0] held_slots   [$];   // slots the plan copy has handed out

    rsp_item_t   oldest_rsp;
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned stall_left;
    logic        sender_steady;
    logic        receiver_steady;

    always #5 clk = ~clk;

    // slots in use: the register clamped to [2, min(256, MAX_SLOTS)]
    function automatic int unsigned pool_size(int p);
        int unsigned c;
        c = 32'(count_reg[p]);
        if (c < 32'(COUNT_MIN))
            c = 32'(COUNT_MIN);
        if (c > SLOT_CAP)
            c = SLOT_CAP;
        if (c > MAX_SLOTS_DEFAULT)
            c = MAX_SLOTS_DEFAULT;
        return c;
    endfunction

    // a count write (or reset) re-forms the chain 1,2,...,count-1 ending in 0
    function automatic void pool_rebuild(int p, logic [COUNT_W-1:0] value);
        int unsigned c;
        count_reg[p] = value;
        c = pool_size(p);
        for (int i = 0; i < SLOT_CAP; i++)
            link_mem[p][i] = '0;
        for (int i = 1; i < c; i++)
            link_mem[p][i] = (i + 1 < c) ? SLOT_W'(i + 1) : '0;
        head_slot[p] = SLOT_W'(1);
    endfunction

    // response of one item, and its effect on the free list
    function automatic rsp_item_t pool_apply(int p, req_item_t it);
        rsp_item_t   r;
        int unsigned c;
        c = pool_size(p);
        r.granted_slot = '0;
        if (it.action == ACT_OBTAIN)
        begin
            if (head_slot[p] == 0 || head_slot[p] >= c)
                r.status = ST_EMPTY;
            else
            begin
                // pop the head; a double return may have left a loop, follow it
                r.status       = ST_GRANTED;
                r.granted_slot = head_slot[p];
                head_slot[p]   = link_mem[p][head_slot[p]];
            end
        end
        else if (it.slot == 0 || it.slot >= c)
            r.status = ST_REFUSED;   // sentinel or beyond the pool: list untouched
        else
        begin
            // push, even if the slot is already free
            link_mem[p][it.slot] = head_slot[p];
            head_slot[p]         = it.slot;
            r.status             = ST_RETURNED;
        end
        return r;
    endfunction

    // queue one item and run it through the plan copy to know which slots are out
    function automatic void plan_item(logic act, logic [SLOT_W-1:0] s);
        req_item_t it;
        rsp_item_t r;
        it.action = act;
        it.slot   = s;
        pending_reqs.push_back(it);
        r = pool_apply(POOL_PLAN, it);
        if (r.status == ST_GRANTED)
            held_slots.push_back(r.granted_slot);
        else if (r.status == ST_RETURNED)
        begin
            for (int i = 0; i < held_slots.size(); i++)
            begin
                if (held_slots[i] == s)
                begin
                    held_slots.delete(i);
                    break;
                end
            end
        end
    endfunction

    // mostly obtains and returns of held slots; some refused and stray returns
    function automatic void plan_random(int n, int unsigned obtain_pct);
        int unsigned c;
        int unsigned r;
        int unsigned k;
        repeat (n)
        begin
            c = pool_size(POOL_PLAN);
            r = $urandom_range(0, 99);
            if (r < 2)
                plan_item(ACT_RETURN, SLOT_W'($urandom));
            else if (r < 8)
            begin
                // refused return: on odd draws past the end when the pool is short, else slot 0
                if (r[0] && c < SLOT_CAP)
                    plan_item(ACT_RETURN, SLOT_W'($urandom_range(c, SLOT_CAP - 1)));
                else
                    plan_item(ACT_RETURN, '0);
            end
            else if (r < 14)
                plan_item(ACT_RETURN, SLOT_W'($urandom_range(1, c - 1)));   // maybe double
            else if (held_slots.size() == 0 || $urandom_range(0, 99) < obtain_pct)
                plan_item(ACT_OBTAIN, SLOT_W'($urandom));   // slot field is don't-care
            else
            begin
                k = $urandom_range(0, held_slots.size() - 1);
                plan_item(ACT_RETURN, held_slots[k]);
            end
        end
    endfunction

    // count write, only called with the core idle
    task automatic write_count(logic [COUNT_W-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        pool_rebuild(POOL_LIVE, value);
        pool_rebuild(POOL_PLAN, value);
        held_slots.delete();
        // some phases run without any idling on one side or both
        sender_steady   = ($urandom_range(0, 3) == 0);
        receiver_steady = ($urandom_range(0, 3) == 0);
    endtask

    // every item accepted and answered, then a pause for the grant path to settle
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || awaited_rsps.size() != 0 || req.valid)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // request driver: bursts of items with random gaps; valid holds until taken
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req.valid  <= 1'b0;
            req.action <= ACT_OBTAIN;
            req.slot   <= '0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                awaited_rsps.push_back(pool_apply(POOL_LIVE, pending_reqs.pop_front()));
            if (!req.valid || req.ready)
            begin
                if (gap_left != 0 && !sender_steady)
                begin
                    gap_left--;
                    req.valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    req.valid  <= 1'b1;
                    req.action <= pending_reqs[0].action;
                    req.slot   <= pending_reqs[0].slot;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
                    end
                    else
                        burst_left--;
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // response side: ready mostly high, with stall runs of random length
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left != 0 && !receiver_steady)
        begin
            rsp.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            rsp.ready <= 1'b1;
            if ($urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 9);
        end
    end

    // monitor: each taken response against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (awaited_rsps.size() == 0)
            begin
                $error("response with no item waiting: status %0d granted_slot %0d",
                       rsp.status, rsp.granted_slot);
                error_count++;
            end
            else
            begin
                oldest_rsp = awaited_rsps.pop_front();
                if (rsp.status !== oldest_rsp.status)
                begin
                    $error("status: expected %0d actual %0d", oldest_rsp.status, rsp.status);
                    error_count++;
                end
                if (rsp.granted_slot !== oldest_rsp.granted_slot)
                begin
                    $error("granted_slot: expected %0d actual %0d",
                           oldest_rsp.granted_slot, rsp.granted_slot);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        req.valid       = 1'b0;
        req.action      = ACT_OBTAIN;
        req.slot        = '0;
        rsp.ready       = 1'b0;
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
        error_count     = 0;
        cycle_count     = 0;
        pool_rebuild(POOL_LIVE, COUNT_RESET);
        pool_rebuild(POOL_PLAN, COUNT_RESET);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset count of 256: top slot, sentinel return, return of a free slot
        plan_item(ACT_OBTAIN, 8'hFF);
        plan_item(ACT_OBTAIN, 8'h00);
        plan_item(ACT_RETURN, 8'h00);
        plan_item(ACT_RETURN, 8'hFF);
        plan_item(ACT_OBTAIN, 8'h00);
        plan_item(ACT_RETURN, 8'h01);
        plan_item(ACT_RETURN, 8'h02);
        plan_item(ACT_OBTAIN, 8'h5A);
        plan_item(ACT_OBTAIN, 8'hA5);
        plan_random(120, 55);
        wait_idle();

        // small pool: run dry, double return into a loop, returns past the end
        write_count(9'd4);
        repeat (4) plan_item(ACT_OBTAIN, 8'h00);
        plan_item(ACT_RETURN, 8'h03);
        plan_item(ACT_RETURN, 8'h03);
        repeat (3) plan_item(ACT_OBTAIN, 8'h00);
        plan_item(ACT_RETURN, 8'h04);
        plan_item(ACT_RETURN, 8'h00);
        plan_item(ACT_RETURN, 8'hFF);
        plan_item(ACT_RETURN, 8'h01);
        plan_item(ACT_OBTAIN, 8'h00);
        plan_random(100, 50);
        wait_idle();

        // counts below the minimum clamp to a single usable slot
        write_count(9'd0);
        plan_random(60, 50);
        wait_idle();
        write_count(9'd1);
        plan_random(60, 50);
        wait_idle();
        write_count(COUNT_MIN);
        plan_item(ACT_OBTAIN, 8'h00);
        plan_item(ACT_OBTAIN, 8'h00);
        plan_item(ACT_RETURN, 8'h01);
        plan_item(ACT_RETURN, 8'h02);
        plan_random(60, 50);
        wait_idle();

        // counts above 256 clamp; a run heavy in obtains on the full pool
        write_count(9'd511);
        plan_random(320, 88);
        wait_idle();
        write_count(9'd257);
        plan_random(150, 50);
        wait_idle();

        write_count(9'd3);
        plan_random(100, 50);
        wait_idle();
        write_count(9'd256);
        plan_random(200, 60);
        wait_idle();
        write_count(COUNT_W'($urandom_range(5, 40)));
        plan_random(200, 55);
        wait_idle();
        write_count(COUNT_W'($urandom_range(0, 511)));
        plan_random(150, 50);
        wait_idle();

        repeat (6) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/fla_pkg.sv
rtl/fla_ifs.sv
rtl/free_list_slot_allocator_core.sv
verif/free_list_slot_allocator_core_tb.sv
